// ===== rtl/core/csdp_pkg.sv =====
// Shared widths, register indexes, saturation limits and queue entry type of the dot product unit.
package csdp_pkg;

    localparam int WEIGHT_W    = 16;
    localparam int SAMPLE_W    = 16;
    localparam int BIAS_W      = 32;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 48;
    localparam int RESULT_W    = 32;
    localparam int COUNT_W     = 32;
    localparam int CHUNK_W     = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam int MAX_CHUNK   = 2048;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 12'd2048;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_SAMPLES = 1'd1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_MIN = 48'shFFFF_8000_0000;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic signed [BIAS_W-1:0] bias;
        logic                     first;
        logic                     clip;
        logic                     last;
    } t_elem;

endpackage

// ===== rtl/core/csdp_elem_if.sv =====
// Element channel: valid/ready handshake with weight, sample, bias and row markers.
interface csdp_elem_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [csdp_pkg::WEIGHT_W-1:0]   weight;
    logic signed [csdp_pkg::SAMPLE_W-1:0]   sample;
    logic signed [csdp_pkg::BIAS_W-1:0]     bias;
    logic                                   first_element;
    logic                                   last_element;

    modport source (
        output valid, weight, sample, bias, first_element, last_element,
        input  ready
    );
    modport sink (
        input  valid, weight, sample, bias, first_element, last_element,
        output ready
    );
endinterface

// ===== rtl/core/csdp_result_if.sv =====
// Result channel: valid/ready handshake with the row result and the clip total.
interface csdp_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [csdp_pkg::RESULT_W-1:0]   row_result;
    logic        [csdp_pkg::COUNT_W-1:0]    clip_total;

    modport source (
        output valid, row_result, clip_total,
        input  ready
    );
    modport sink (
        input  valid, row_result, clip_total,
        output ready
    );
endinterface

// ===== rtl/core/csdp_front.sv =====
// Front end: configuration registers, element accept, multiply and chunk boundary tracking.
module csdp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csdp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [csdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    csdp_elem_if.sink                          i_elem,
    input  logic                               i_q_full,
    output logic                               o_push,
    output csdp_pkg::t_elem                    o_entry
);

    logic [csdp_pkg::CHUNK_W-1:0]        r_chunk_length;
    logic                                r_byte_samples;
    logic [csdp_pkg::CHUNK_W-1:0]        r_pos;
    logic [csdp_pkg::CHUNK_W-1:0]        n_pos;
    logic [csdp_pkg::CHUNK_W-1:0]        eff_length;
    logic [csdp_pkg::CHUNK_W-1:0]        pos_base;
    logic [csdp_pkg::CHUNK_W-1:0]        pos_inc;
    logic                                clip;
    logic signed [csdp_pkg::SAMPLE_W-1:0] sample_ext;
    logic signed [csdp_pkg::PROD_W-1:0]   product;

    assign i_elem.ready = !i_q_full;
    assign o_push       = i_elem.valid && !i_q_full;

    always_comb begin
        if (r_chunk_length == '0) begin
            eff_length = csdp_pkg::CHUNK_W'(1);
        end else if (32'(r_chunk_length) > csdp_pkg::MAX_CHUNK) begin
            eff_length = csdp_pkg::CHUNK_W'(csdp_pkg::MAX_CHUNK);
        end else begin
            eff_length = r_chunk_length;
        end
    end

    always_comb begin
        pos_base = i_elem.first_element ? '0 : r_pos;
        pos_inc  = pos_base + 1'b1;
        clip     = (pos_inc >= eff_length) || (pos_inc == '0) || i_elem.last_element;
        n_pos    = clip ? '0 : pos_inc;
    end

    always_comb begin
        if (r_byte_samples) begin
            sample_ext = {{8{i_elem.sample[7]}}, i_elem.sample[7:0]};
        end else begin
            sample_ext = i_elem.sample;
        end
        product = i_elem.weight * sample_ext;
    end

    always_comb begin
        o_entry.product = product;
        o_entry.bias    = i_elem.bias;
        o_entry.first   = i_elem.first_element;
        o_entry.clip    = clip;
        o_entry.last    = i_elem.last_element;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_length <= csdp_pkg::CHUNK_RESET;
            r_byte_samples <= 1'b0;
            r_pos          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    csdp_pkg::REG_CHUNK_LENGTH: begin
                        r_chunk_length <= i_cfg_data;
                    end
                    csdp_pkg::REG_BYTE_SAMPLES: begin
                        r_byte_samples <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

// ===== rtl/core/csdp_queue.sv =====
// Short register queue that decouples the front end from the accumulator.
module csdp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  csdp_pkg::t_elem  i_entry,
    output logic             o_full,
    output logic             o_valid,
    output csdp_pkg::t_elem  o_entry,
    input  logic             i_pop
);

    localparam int DEPTH = csdp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csdp_pkg::t_elem     r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("Queue popped while empty.");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + CNT_W'($past(i_push)) - CNT_W'($past(i_pop)))
        else $error("Queue count does not follow pushes and pops.");

endmodule

// ===== rtl/core/csdp_back.sv =====
// Back end: wide accumulation, saturation, clip counting and the result register.
module csdp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  csdp_pkg::t_elem  i_entry,
    output logic             o_pop,
    csdp_result_if.source    o_result
);

    logic signed [csdp_pkg::SUM_W-1:0]    r_sum;
    logic signed [csdp_pkg::SUM_W-1:0]    n_sum;
    logic signed [csdp_pkg::SUM_W-1:0]    base;
    logic signed [csdp_pkg::SUM_W-1:0]    acc;
    logic [csdp_pkg::COUNT_W-1:0]         r_count;
    logic [csdp_pkg::COUNT_W-1:0]         n_count;
    logic                                 r_out_valid;
    logic signed [csdp_pkg::RESULT_W-1:0] r_row_result;
    logic [csdp_pkg::COUNT_W-1:0]         r_clip_total;

    assign o_pop = i_valid && (!i_entry.last || !r_out_valid || o_result.ready);

    always_comb begin
        if (i_entry.first) begin
            base = {{(csdp_pkg::SUM_W - csdp_pkg::BIAS_W){i_entry.bias[csdp_pkg::BIAS_W-1]}},
                    i_entry.bias};
        end else begin
            base = r_sum;
        end
        acc     = base + {{(csdp_pkg::SUM_W - csdp_pkg::PROD_W){
                      i_entry.product[csdp_pkg::PROD_W-1]}}, i_entry.product};
        n_sum   = acc;
        n_count = r_count;
        if (i_entry.clip) begin
            if (acc > csdp_pkg::SAT_MAX) begin
                n_sum   = csdp_pkg::SAT_MAX;
                n_count = r_count + 1'b1;
            end else if (acc < csdp_pkg::SAT_MIN) begin
                n_sum   = csdp_pkg::SAT_MIN;
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_row_result <= n_sum[csdp_pkg::RESULT_W-1:0];
            r_clip_total <= n_count;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.row_result = r_row_result;
    assign o_result.clip_total = r_clip_total;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_entry.last |=> r_out_valid)
        else $error("Last element did not produce a result.");

    a_clip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_entry.clip |=> (r_sum <= csdp_pkg::SAT_MAX) && (r_sum >= csdp_pkg::SAT_MIN))
        else $error("Clipped sum left the signed 32-bit range.");

endmodule

// ===== rtl/core/chunked_saturating_dot_product_unit.sv =====
// Top level of the chunked saturating dot product unit.
// The unit accepts one element transaction per clock cycle for any row length, while results
// are taken as they are offered. The front end multiplies weight by sample and decides chunk
// boundaries in the accept cycle, writing a two-entry queue; the back end performs the 48-bit
// accumulate and saturation of each element in one loop through its sum register, which sets
// that rate. A row result transaction is offered once its last element has left the queue
// and been accumulated, and is held in an output register, so elements keep flowing while a
// result waits to be taken, until the next row's last element reaches the back end and waits.
module chunked_saturating_dot_product_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csdp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [csdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    csdp_elem_if.sink                          i_elem,
    csdp_result_if.source                      o_result
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    csdp_pkg::t_elem  push_entry;
    csdp_pkg::t_elem  head_entry;

    csdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_elem      (i_elem),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    csdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    csdp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
